>>> hdl/sct_pkg.sv
// Shared types and constants for the sine/cosine series pipeline.
// Depends on nothing; every other file of the block but sct_mul64 refers to it by scoped names.
`timescale 1ns / 1ps

package sct_pkg;

    // Fraction bits of the internal fixed-point format (signed Q5.58).
    localparam int QF = 58;

    // Latency of the partial-product multiplier in cycles.
    localparam int MUL_LAT = 3;

    // Width of a term magnitude.
    localparam int MAG_W = 63;

    // 1/(2pi) as unsigned Q0.64, truncated.
    localparam logic [63:0] INV2PI_Q64 = 64'h28BE_60DB_9391_054A;

    // 2pi as Q5.58, rounded to nearest.
    localparam logic [63:0] TWO_PI_Q58 = 64'h1921_FB54_442D_1847;

    // One in Q5.58.
    localparam logic [MAG_W-1:0] ONE_Q58 = 63'd1 << QF;

    // 2^63, numerator of the reciprocals of the factorial divisors.
    localparam logic [63:0] HALF_Q63 = 64'h8000_0000_0000_0000;

    // A series term kept as sign and magnitude.
    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } term_t;

    // Everything one item carries from one series cell to the next.
    typedef struct packed {
        term_t              s_term;
        term_t              c_term;
        logic signed [63:0] s_sum;
        logic signed [63:0] c_sum;
        logic [MAG_W-1:0]   x2;
    } link_t;

endpackage

>>> hdl/sct_mul64.sv
// Pipelined 64 x 64 unsigned multiplier built from four 32 x 32 partial products.
// Three register stages; depends on nothing but the enable it is given.
`timescale 1ns / 1ps

module sct_mul64 (
    input  logic         aclk,
    input  logic         en,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    output logic [127:0] p
);

    logic [63:0]  ll_reg, lh_reg, hl_reg, hh_reg;
    logic [63:0]  ll_next, lh_next, hl_next, hh_next;
    logic [64:0]  mid_reg, mid_next;
    logic [127:0] cat_reg, cat_next;
    logic [127:0] p_reg, p_next;

    // Stage 1: the four partial products.
    always_comb begin
        ll_next = 64'(a[31:0]) * 64'(b[31:0]);
        lh_next = 64'(a[31:0]) * 64'(b[63:32]);
        hl_next = 64'(a[63:32]) * 64'(b[31:0]);
        hh_next = 64'(a[63:32]) * 64'(b[63:32]);
    end

    // Stage 2: the cross terms are summed; the outer terms do not overlap.
    always_comb begin
        mid_next = 65'(lh_reg) + 65'(hl_reg);
        cat_next = {hh_reg, ll_reg};
    end

    // Stage 3: final carry-propagate add.
    always_comb begin
        p_next = cat_reg + {31'd0, mid_reg, 32'd0};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            ll_reg  <= ll_next;
            lh_reg  <= lh_next;
            hl_reg  <= hl_next;
            hh_reg  <= hh_next;
            mid_reg <= mid_next;
            cat_reg <= cat_next;
            p_reg   <= p_next;
        end
    end

    assign p = p_reg;

endmodule

>>> hdl/sct_reduce.sv
// Range reduction of the input angle and the square of the reduced angle.
// Depends on sct_pkg and sct_mul64; feeds the first series cell.
`timescale 1ns / 1ps

module sct_reduce #(
    parameter int ANGLE_FRAC_BITS = 16
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                en,
    input  logic                in_vld,
    input  logic [31:0]         in_angle,
    output logic                out_vld,
    output sct_pkg::link_t      out_link
);

    localparam int KW       = 32 - ANGLE_FRAC_BITS;
    localparam int K_SHIFT  = ANGLE_FRAC_BITS + 32;
    localparam int M_SHIFT  = sct_pkg::QF - ANGLE_FRAC_BITS;
    localparam int PRE_LAT  = 5;
    localparam int RED_LAT  = PRE_LAT + sct_pkg::MUL_LAT;
    localparam int MW       = sct_pkg::MAG_W;
    localparam logic [63:0] ROUND_HALF = 64'd1 << (ANGLE_FRAC_BITS + 31);

    // Stage 1: magnitude of the angle times 1/(2pi), in two halves.
    logic        neg1_reg, neg1_next;
    logic [31:0] m1_reg, m1_next;
    logic [63:0] plo1_reg, plo1_next, phi1_reg, phi1_next;
    // Stage 2: rounded count of whole turns.
    logic          neg2_reg;
    logic [31:0]   m2_reg;
    logic [KW-1:0] k2_reg, k2_next;
    logic [63:0]   t2;
    // Stage 3: turns times 2pi, modulo 2^64, and the angle in Q58.
    logic        neg3_reg;
    logic [63:0] msh3_reg, msh3_next, kplo3_reg, kplo3_next;
    logic [31:0] kphi3_reg, kphi3_next;
    // Stage 4: reduced angle magnitude with its own sign.
    logic        neg4_reg;
    logic [63:0] rm4_reg, rm4_next;
    // Stage 5: signed reduced angle and its magnitude.
    logic signed [63:0] r5_reg, r5_next;
    logic               sneg5_reg, sneg5_next;
    logic [MW-1:0]      rmag5_reg, rmag5_next;

    logic signed [63:0] dr_reg   [sct_pkg::MUL_LAT];
    logic               dneg_reg [sct_pkg::MUL_LAT];
    logic [MW-1:0]      dmag_reg [sct_pkg::MUL_LAT];

    logic [RED_LAT-1:0] vld_reg, vld_next;
    logic [127:0]       sq_prod;

    always_comb begin
        neg1_next = in_angle[31];
        m1_next   = in_angle[31] ? 32'd0 - in_angle : in_angle;
        plo1_next = 64'(m1_next) * 64'(sct_pkg::INV2PI_Q64[31:0]);
        phi1_next = 64'(m1_next) * 64'(sct_pkg::INV2PI_Q64[63:32]);
    end

    always_comb begin
        t2      = phi1_reg + (plo1_reg >> 32);
        k2_next = KW'((t2 + ROUND_HALF) >> K_SHIFT);
    end

    always_comb begin
        msh3_next  = 64'(m2_reg) << M_SHIFT;
        kplo3_next = 64'(k2_reg) * 64'(sct_pkg::TWO_PI_Q58[31:0]);
        kphi3_next = 32'(64'(k2_reg) * 64'(sct_pkg::TWO_PI_Q58[63:32]));
    end

    always_comb begin
        rm4_next = msh3_reg - kplo3_reg - {kphi3_reg, 32'd0};
    end

    always_comb begin
        r5_next    = neg4_reg ? 64'd0 - rm4_reg : rm4_reg;
        sneg5_next = rm4_reg[63] ^ neg4_reg;
        rmag5_next = MW'(rm4_reg[63] ? 64'd0 - rm4_reg : rm4_reg);
    end

    assign vld_next = {vld_reg[RED_LAT-2:0], in_vld};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            neg1_reg  <= neg1_next;
            m1_reg    <= m1_next;
            plo1_reg  <= plo1_next;
            phi1_reg  <= phi1_next;
            neg2_reg  <= neg1_reg;
            m2_reg    <= m1_reg;
            k2_reg    <= k2_next;
            neg3_reg  <= neg2_reg;
            msh3_reg  <= msh3_next;
            kplo3_reg <= kplo3_next;
            kphi3_reg <= kphi3_next;
            neg4_reg  <= neg3_reg;
            rm4_reg   <= rm4_next;
            r5_reg    <= r5_next;
            sneg5_reg <= sneg5_next;
            rmag5_reg <= rmag5_next;
            dr_reg[0]   <= r5_reg;
            dneg_reg[0] <= sneg5_reg;
            dmag_reg[0] <= rmag5_reg;
            for (int i = 1; i < sct_pkg::MUL_LAT; i++) begin
                dr_reg[i]   <= dr_reg[i-1];
                dneg_reg[i] <= dneg_reg[i-1];
                dmag_reg[i] <= dmag_reg[i-1];
            end
        end
    end

    sct_mul64 u_square (
        .aclk (aclk),
        .en   (en),
        .a    ({1'b0, rmag5_reg}),
        .b    ({1'b0, rmag5_reg}),
        .p    (sq_prod)
    );

    // The square is non-negative; its magnitude keeps Q58 bits, masked to 63.
    always_comb begin
        out_link.s_term.neg = dneg_reg[sct_pkg::MUL_LAT-1];
        out_link.s_term.mag = dmag_reg[sct_pkg::MUL_LAT-1];
        out_link.c_term.neg = 1'b0;
        out_link.c_term.mag = sct_pkg::ONE_Q58;
        out_link.s_sum      = dr_reg[sct_pkg::MUL_LAT-1];
        out_link.c_sum      = $signed({1'b0, sct_pkg::ONE_Q58});
        out_link.x2         = sq_prod[sct_pkg::QF+MW-1:sct_pkg::QF];
    end

    assign out_vld = vld_reg[RED_LAT-1];

endmodule

>>> hdl/sct_cell.sv
// One series cell: next sine and cosine terms and the running sums.
// Depends on sct_pkg and sct_mul64; instantiated once per term after the first.
`timescale 1ns / 1ps

module sct_cell #(
    parameter int TERM_IDX = 1
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           en,
    input  logic           in_vld,
    input  sct_pkg::link_t in_link,
    output logic           out_vld,
    output sct_pkg::link_t out_link
);

    localparam int MW       = sct_pkg::MAG_W;
    localparam int ML       = sct_pkg::MUL_LAT;
    localparam int CELL_LAT = 2 * ML + 3;
    localparam int S_DIV    = (2 * TERM_IDX) * (2 * TERM_IDX + 1);
    localparam int C_DIV    = (2 * TERM_IDX - 1) * (2 * TERM_IDX);
    // The remainder after the reciprocal estimate stays below twice the divisor.
    localparam int RW       = $clog2(S_DIV) + 1;
    localparam logic [RW-1:0] S_DIV_RW = RW'(S_DIV);
    localparam logic [RW-1:0] C_DIV_RW = RW'(C_DIV);
    localparam logic [63:0]   S_RECIP  = sct_pkg::HALF_Q63 / 64'(S_DIV);
    localparam logic [63:0]   C_RECIP  = sct_pkg::HALF_Q63 / 64'(C_DIV);

    logic [127:0] s_prod, c_prod, s_qprod, c_qprod;
    logic [MW-1:0] pm_s, pm_c, q0_s, q0_c;

    sct_pkg::link_t a_lnk_reg [ML];
    sct_pkg::link_t b_lnk_reg [ML];
    logic [RW-1:0]  b_pms_reg [ML];
    logic [RW-1:0]  b_pmc_reg [ML];

    sct_pkg::link_t c_lnk_reg;
    logic [MW-1:0]  c_q0s_reg, c_q0c_reg;
    logic [RW-1:0]  c_rems_reg, c_rems_next, c_remc_reg, c_remc_next;

    sct_pkg::link_t d_lnk_reg;
    logic [MW-1:0]  d_qs_reg, d_qs_next, d_qc_reg, d_qc_next;

    sct_pkg::link_t     e_lnk_reg, e_lnk_next;
    logic               s_neg_new, c_neg_new;
    logic signed [63:0] s_add, c_add;

    logic [CELL_LAT-1:0] vld_reg, vld_next;

    // Term times x squared; x squared is never negative.
    sct_mul64 u_mul_s (.aclk(aclk), .en(en), .a({1'b0, in_link.s_term.mag}),
                       .b({1'b0, in_link.x2}), .p(s_prod));
    sct_mul64 u_mul_c (.aclk(aclk), .en(en), .a({1'b0, in_link.c_term.mag}),
                       .b({1'b0, in_link.x2}), .p(c_prod));

    assign pm_s = s_prod[sct_pkg::QF+MW-1:sct_pkg::QF];
    assign pm_c = c_prod[sct_pkg::QF+MW-1:sct_pkg::QF];

    // Quotient estimate by the truncated reciprocal: exact or one short.
    sct_mul64 u_div_s (.aclk(aclk), .en(en), .a({1'b0, pm_s}), .b(S_RECIP), .p(s_qprod));
    sct_mul64 u_div_c (.aclk(aclk), .en(en), .a({1'b0, pm_c}), .b(C_RECIP), .p(c_qprod));

    assign q0_s = s_qprod[MW+62:63];
    assign q0_c = c_qprod[MW+62:63];

    // Only the low bits of the remainder are needed, since it is small.
    always_comb begin
        c_rems_next = b_pms_reg[ML-1] - q0_s[RW-1:0] * S_DIV_RW;
        c_remc_next = b_pmc_reg[ML-1] - q0_c[RW-1:0] * C_DIV_RW;
    end

    always_comb begin
        d_qs_next = c_q0s_reg + MW'(c_rems_reg >= S_DIV_RW);
        d_qc_next = c_q0c_reg + MW'(c_remc_reg >= C_DIV_RW);
    end

    // Each new term flips the sign of the previous one.
    always_comb begin
        s_neg_new  = !d_lnk_reg.s_term.neg;
        c_neg_new  = !d_lnk_reg.c_term.neg;
        s_add      = s_neg_new ? 64'd0 - {1'b0, d_qs_reg} : {1'b0, d_qs_reg};
        c_add      = c_neg_new ? 64'd0 - {1'b0, d_qc_reg} : {1'b0, d_qc_reg};
        e_lnk_next = d_lnk_reg;
        e_lnk_next.s_term.neg = s_neg_new;
        e_lnk_next.s_term.mag = d_qs_reg;
        e_lnk_next.c_term.neg = c_neg_new;
        e_lnk_next.c_term.mag = d_qc_reg;
        e_lnk_next.s_sum      = d_lnk_reg.s_sum + s_add;
        e_lnk_next.c_sum      = d_lnk_reg.c_sum + c_add;
    end

    assign vld_next = {vld_reg[CELL_LAT-2:0], in_vld};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            a_lnk_reg[0] <= in_link;
            b_lnk_reg[0] <= a_lnk_reg[ML-1];
            b_pms_reg[0] <= pm_s[RW-1:0];
            b_pmc_reg[0] <= pm_c[RW-1:0];
            for (int i = 1; i < ML; i++) begin
                a_lnk_reg[i] <= a_lnk_reg[i-1];
                b_lnk_reg[i] <= b_lnk_reg[i-1];
                b_pms_reg[i] <= b_pms_reg[i-1];
                b_pmc_reg[i] <= b_pmc_reg[i-1];
            end
            c_lnk_reg  <= b_lnk_reg[ML-1];
            c_q0s_reg  <= q0_s;
            c_q0c_reg  <= q0_c;
            c_rems_reg <= c_rems_next;
            c_remc_reg <= c_remc_next;
            d_lnk_reg  <= c_lnk_reg;
            d_qs_reg   <= d_qs_next;
            d_qc_reg   <= d_qc_next;
            e_lnk_reg  <= e_lnk_next;
        end
    end

    assign out_vld  = vld_reg[CELL_LAT-1];
    assign out_link = e_lnk_reg;

endmodule

>>> hdl/sct_round.sv
// Output formatting: rounding of both Q58 sums to the result format and saturation.
// Depends on sct_pkg; three register stages, sine in lane 0, cosine in lane 1.
`timescale 1ns / 1ps

module sct_round #(
    parameter int RESULT_FRAC_BITS = 30
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               en,
    input  logic               in_vld,
    input  logic signed [63:0] in_sum [2],
    output logic               out_vld,
    output logic [63:0]        out_data
);

    localparam int RND_LAT = 3;
    localparam logic [63:0] ONE_R = 64'd1 << RESULT_FRAC_BITS;

    logic        neg1_reg [2];
    logic [63:0] mag1_reg [2];
    logic [63:0] mag1_next [2];
    logic [63:0] scaled [2];
    logic [63:0] sat [2];
    logic        neg2_reg [2];
    logic [31:0] sat2_reg [2];
    logic [31:0] res3_reg [2];
    logic [31:0] res3_next [2];
    logic [RND_LAT-1:0] vld_reg, vld_next;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            mag1_next[l] = in_sum[l][63] ? 64'd0 - in_sum[l] : in_sum[l];
        end
    end

    generate
        if (RESULT_FRAC_BITS < sct_pkg::QF) begin : g_down
            localparam int SH = sct_pkg::QF - RESULT_FRAC_BITS;
            localparam logic [63:0] HALF_LSB = 64'd1 << (SH - 1);
            always_comb begin
                for (int l = 0; l < 2; l++) begin
                    scaled[l] = (mag1_reg[l] + HALF_LSB) >> SH;
                end
            end
        end else if (RESULT_FRAC_BITS == sct_pkg::QF) begin : g_same
            always_comb begin
                for (int l = 0; l < 2; l++) begin
                    scaled[l] = mag1_reg[l];
                end
            end
        end else begin : g_up
            localparam int SH = RESULT_FRAC_BITS - sct_pkg::QF;
            localparam logic [63:0] LIM = ONE_R >> SH;
            always_comb begin
                for (int l = 0; l < 2; l++) begin
                    scaled[l] = (mag1_reg[l] > LIM) ? ONE_R : (mag1_reg[l] << SH);
                end
            end
        end
    endgenerate

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            sat[l]       = (scaled[l] > ONE_R) ? ONE_R : scaled[l];
            res3_next[l] = neg2_reg[l] ? 32'd0 - sat2_reg[l] : sat2_reg[l];
        end
    end

    assign vld_next = {vld_reg[RND_LAT-2:0], in_vld};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else if (en) begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            for (int l = 0; l < 2; l++) begin
                neg1_reg[l] <= in_sum[l][63];
                mag1_reg[l] <= mag1_next[l];
                neg2_reg[l] <= neg1_reg[l];
                sat2_reg[l] <= sat[l][31:0];
                res3_reg[l] <= res3_next[l];
            end
        end
    end

    assign out_vld  = vld_reg[RND_LAT-1];
    assign out_data = {res3_reg[1], res3_reg[0]};

endmodule

>>> hdl/sine_cosine_taylor_series.sv
// Top level of the sine/cosine block: input and result channels, the cell chain.
// Depends on sct_pkg, sct_reduce, sct_cell, sct_round and sct_mul64.
//
// Usage:
// An angle item enters on the s_ channel as signed fixed point with ANGLE_FRAC_BITS
// fraction bits. It is reduced by whole turns to about [-pi, pi], squared, and then
// passes a chain of SERIES_TERMS-1 per-term cells. Each cell forms the next sine
// and cosine term from the previous one and x squared, divides it by its two
// factorial factors with a reciprocal multiply and one correction, and adds it to
// the running sums. The sums are rounded to RESULT_FRAC_BITS fraction bits,
// saturated to plus or minus one, and leave as one item on the m_ channel.
//
// Throughput is one item per clock while the chain is not held by a stall at the
// output (see below). From acceptance to m_tvalid an item passes the reduction,
// each cell (two three-stage partial-product multipliers and three adder
// stages), the rounding and the output register.
//
// The whole chain moves on one enable. While the output register holds an item
// that is not taken, the chain still advances as long as no finished item is
// about to reach it; only then does it hold and s_tready go low.
// Reset (aresetn low, synchronous) clears every valid flag; items in flight are dropped.
// s_tready stays low while reset is held, so no item is taken during reset.
`timescale 1ns / 1ps

module sine_cosine_taylor_series #(
    parameter int SERIES_TERMS     = 16,
    parameter int ANGLE_FRAC_BITS  = 16,
    parameter int RESULT_FRAC_BITS = 30
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input channel. s_tdata: [31:0] angle.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,
    // Result channel. m_tdata: [31:0] sine, [63:32] cosine.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [63:0] m_tdata
);

    // Largest result magnitude that fits the 32-bit field, for the range check.
    localparam int OUT_ONE_SHIFT = (RESULT_FRAC_BITS > 30) ? 30 : RESULT_FRAC_BITS;
    localparam logic signed [32:0] OUT_ONE = 33'sd1 <<< OUT_ONE_SHIFT;

    logic                  advance;
    logic                  chain_vld  [SERIES_TERMS];
    sct_pkg::link_t        chain_link [SERIES_TERMS];
    logic signed [63:0]    fin_sum [2];
    logic                  pipe_vld;
    logic [63:0]           pipe_data;
    logic                  m_tvalid_reg, m_tvalid_next;
    logic [63:0]           m_tdata_reg, m_tdata_next;

    // The chain holds only when a finished item would land on an occupied,
    // stalled output register.
    assign advance  = !(m_tvalid_reg && !m_tready && pipe_vld);
    assign s_tready = advance && aresetn;

    sct_reduce #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_reduce (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (advance),
        .in_vld   (s_tvalid),
        .in_angle (s_tdata[31:0]),
        .out_vld  (chain_vld[0]),
        .out_link (chain_link[0])
    );

    // One cell per series term after the first.
    genvar gi;
    generate
        for (gi = 1; gi < SERIES_TERMS; gi++) begin : g_cell
            sct_cell #(
                .TERM_IDX (gi)
            ) u_cell (
                .aclk     (aclk),
                .aresetn  (aresetn),
                .en       (advance),
                .in_vld   (chain_vld[gi-1]),
                .in_link  (chain_link[gi-1]),
                .out_vld  (chain_vld[gi]),
                .out_link (chain_link[gi])
            );
        end
    endgenerate

    assign fin_sum[0] = chain_link[SERIES_TERMS-1].s_sum;
    assign fin_sum[1] = chain_link[SERIES_TERMS-1].c_sum;

    sct_round #(
        .RESULT_FRAC_BITS (RESULT_FRAC_BITS)
    ) u_round (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .en       (advance),
        .in_vld   (chain_vld[SERIES_TERMS-1]),
        .in_sum   (fin_sum),
        .out_vld  (pipe_vld),
        .out_data (pipe_data)
    );

    // Output register: loads a finished item when the chain advances, and
    // empties when its item is taken and nothing replaces it.
    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (advance && pipe_vld) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = pipe_data;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    // An empty output register never holds back the input side.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled although the output register is empty");

    // A finished item leaving the chain is held in the output register next cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        pipe_vld && advance |=> m_tvalid)
        else $error("finished item lost on its way to the output register");

    // A stalled, occupied output with a finished item behind it freezes the chain.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready && pipe_vld |=> pipe_vld && $stable(pipe_data))
        else $error("chain moved while its finished item could not be stored");

    // Both results stay within plus or minus one when the field can hold one.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (RESULT_FRAC_BITS <= 30) |->
            ($signed(33'($signed(m_tdata[31:0]))) <= OUT_ONE) &&
            ($signed(33'($signed(m_tdata[31:0]))) >= -OUT_ONE) &&
            ($signed(33'($signed(m_tdata[63:32]))) <= OUT_ONE) &&
            ($signed(33'($signed(m_tdata[63:32]))) >= -OUT_ONE))
        else $error("result outside plus or minus one");

endmodule
